>>> rtl/nuf_pkg.sv
`default_nettype none
package nuf_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_UNIT_TYPE    = 2'd0;
    localparam logic [1:0] CFG_LAYER_ID     = 2'd1;
    localparam logic [1:0] CFG_TEMPORAL_ID  = 2'd2;
    localparam logic [1:0] CFG_LEADING_ZERO = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // framing byte values
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONE     = 8'h01;
    localparam logic [7:0] BYTE_PREVENT = 8'h03;

    // descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // header fields seen by the back end
    typedef struct packed {
        logic [5:0] unit_type;
        logic [4:0] layer_id;
        logic [2:0] temporal_id;
    } t_hdr_cfg;

    // one classified payload word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hdr;
        logic       lead;
        logic       ins;
        logic       trail;
    } t_desc;

    // queue head status toward the back end
    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_head;

endpackage
`default_nettype wire

>>> rtl/nuf_front.sv
`default_nettype none
module nuf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_payload_byte,
    input  wire logic          i_payload_last,
    input  wire logic          i_leading_zero,
    input  wire logic          i_full,
    output logic               o_stall,
    output logic               o_push,
    output nuf_pkg::t_desc     o_desc
);

    logic [1:0] r_zero_run;
    logic       r_hdr_pending;
    logic [1:0] n_zero_run;
    logic       n_hdr_pending;

    logic [1:0] zr_start;
    logic       is_zero;
    logic       is_low;
    logic       ins;
    logic [1:0] zr_mid;
    logic [1:0] zr_after;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // zero run tracking and prevention decisions
    always_comb begin
        zr_start = r_hdr_pending ? 2'd0 : r_zero_run;
        is_zero  = (i_payload_byte == nuf_pkg::BYTE_ZERO);
        is_low   = (i_payload_byte[7:2] == 6'd0);
        ins      = (zr_start == 2'd2) && is_low;
        zr_mid   = ins ? 2'd0 : zr_start;
        if (is_zero) begin
            zr_after = (zr_mid == 2'd3) ? 2'd3 : zr_mid + 2'd1;
        end else begin
            zr_after = 2'd0;
        end

        o_desc.data  = i_payload_byte;
        o_desc.last  = i_payload_last;
        o_desc.hdr   = r_hdr_pending;
        o_desc.lead  = r_hdr_pending && i_leading_zero;
        o_desc.ins   = ins;
        o_desc.trail = i_payload_last && (zr_after != 2'd0);

        n_zero_run    = r_zero_run;
        n_hdr_pending = r_hdr_pending;
        if (o_push) begin
            n_zero_run    = i_payload_last ? 2'd0 : zr_after;
            n_hdr_pending = i_payload_last;
        end
    end

    // unit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run    <= 2'd0;
            r_hdr_pending <= 1'b1;
        end else begin
            r_zero_run    <= n_zero_run;
            r_hdr_pending <= n_hdr_pending;
        end
    end

    // a unit always opens with an empty zero run
    a_hdr_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_pending |-> (r_zero_run == 2'd0))
        else $error("zero run not cleared at unit start");

endmodule
`default_nettype wire

>>> rtl/nuf_queue.sv
`default_nettype none
module nuf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire nuf_pkg::t_desc   i_desc,
    input  wire logic             i_pop,
    output logic                  o_full,
    output nuf_pkg::t_q_head      o_head
);

    nuf_pkg::t_desc                 r_mem [nuf_pkg::QUEUE_DEPTH];
    logic [nuf_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [nuf_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [nuf_pkg::QUEUE_CW-1:0]   r_count;
    logic [nuf_pkg::QUEUE_CW-1:0]   n_count;

    assign o_full      = (r_count == nuf_pkg::QUEUE_CW'(nuf_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

>>> rtl/nuf_back.sv
`default_nettype none
module nuf_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nuf_pkg::t_q_head  i_head,
    input  wire nuf_pkg::t_hdr_cfg i_hdr,
    input  wire logic              i_stall,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [7:0]             o_out_byte,
    output logic                   o_run_last,
    output logic                   o_unit_end
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEAD,
        S_Z0,
        S_Z1,
        S_ONE,
        S_H0,
        S_H1,
        S_INS,
        S_BYTE,
        S_TRAIL
    } t_step;

    t_step      r_step;
    t_step      cur_step;
    t_step      n_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_unit_end;
    logic       load;
    logic       emit;
    logic       final_word;
    logic [7:0] cur_byte;
    nuf_pkg::t_desc d;

    assign d          = i_head.desc;
    assign load       = !r_valid || !i_stall;
    assign emit       = load && i_head.valid;
    assign final_word = (n_step == S_IDLE);
    assign o_pop      = emit && final_word;

    // step sequencing within one descriptor
    always_comb begin
        if (r_step == S_IDLE) begin
            if (d.hdr) begin
                cur_step = d.lead ? S_LEAD : S_Z0;
            end else begin
                cur_step = d.ins ? S_INS : S_BYTE;
            end
        end else begin
            cur_step = r_step;
        end

        case (cur_step)
            S_LEAD:  n_step = S_Z0;
            S_Z0:    n_step = S_Z1;
            S_Z1:    n_step = S_ONE;
            S_ONE:   n_step = S_H0;
            S_H0:    n_step = S_H1;
            S_H1:    n_step = d.ins ? S_INS : S_BYTE;
            S_INS:   n_step = S_BYTE;
            S_BYTE:  n_step = d.trail ? S_TRAIL : S_IDLE;
            S_TRAIL: n_step = S_IDLE;
            default: n_step = S_IDLE;
        endcase

        case (cur_step)
            S_LEAD, S_Z0, S_Z1: cur_byte = nuf_pkg::BYTE_ZERO;
            S_ONE:              cur_byte = nuf_pkg::BYTE_ONE;
            S_H0:               cur_byte = {1'b0, i_hdr.unit_type, 1'b0};
            S_H1:               cur_byte = {i_hdr.layer_id, i_hdr.temporal_id};
            S_INS, S_TRAIL:     cur_byte = nuf_pkg::BYTE_PREVENT;
            S_BYTE:             cur_byte = d.data;
            default:            cur_byte = d.data;
        endcase
    end

    // step register and output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= S_IDLE;
            r_valid    <= 1'b0;
            r_byte     <= 8'd0;
            r_run_last <= 1'b0;
            r_unit_end <= 1'b0;
        end else begin
            if (emit) begin
                r_step     <= n_step;
                r_valid    <= 1'b1;
                r_byte     <= cur_byte;
                r_run_last <= final_word;
                r_unit_end <= final_word && d.last;
            end else if (load) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_run_last = r_run_last;
    assign o_unit_end = r_unit_end;

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_unit_end) |-> r_run_last)
        else $error("unit end without run last");

endmodule
`default_nettype wire

>>> rtl/nal_unit_byte_framer.sv
`default_nettype none
// accepted words pass through the descriptor queue and the output word register
// throughput: one word per cycle for plain payload while i_stall is low; an item
// with k result words (start code, header, 0x03 insertions) emits all k before the next
// a two-entry descriptor queue lets input acceptance run ahead of output stalls
// reset: synchronous active low; clears queue and zero run, sets header pending, and
// restores unit_type 32, layer_id 0, temporal_id 1, leading_zero_byte 0
module nal_unit_byte_framer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [7:0]                      i_payload_byte,
    input  wire logic                            i_payload_last,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_run_last,
    output logic                                 o_unit_end,
    input  wire logic                            i_cfg_we,
    input  wire logic [nuf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [nuf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    nuf_pkg::t_hdr_cfg r_hdr;
    logic              r_leading_zero;
    logic              full;
    logic              push;
    logic              pop;
    nuf_pkg::t_desc    desc;
    nuf_pkg::t_q_head  head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr.unit_type   <= 6'd32;
            r_hdr.layer_id    <= 5'd0;
            r_hdr.temporal_id <= 3'd1;
            r_leading_zero    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nuf_pkg::CFG_UNIT_TYPE:    r_hdr.unit_type   <= i_cfg_data[5:0];
                nuf_pkg::CFG_LAYER_ID:     r_hdr.layer_id    <= i_cfg_data[4:0];
                nuf_pkg::CFG_TEMPORAL_ID:  r_hdr.temporal_id <= i_cfg_data[2:0];
                nuf_pkg::CFG_LEADING_ZERO: r_leading_zero    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // classify incoming words
    nuf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_payload_byte (i_payload_byte),
        .i_payload_last (i_payload_last),
        .i_leading_zero (r_leading_zero),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_desc         (desc)
    );

    // descriptor queue
    nuf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // expand descriptors into output words
    nuf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_hdr      (r_hdr),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .o_unit_end (o_unit_end)
    );

endmodule
`default_nettype wire
